/* rtl/lp2p_pkg.sv */
`default_nettype none
package lp2p_pkg;

    // Product codes for the shared 32x32 multiplier sequence.
    localparam logic [1:0] KIND_P = 2'd0;  // |q| * invr >> 24
    localparam logic [1:0] KIND_U = 2'd1;  // |d| * invr >> 24
    localparam logic [1:0] KIND_V = 2'd2;  // P * U >> 32
    localparam logic [1:0] KIND_F = 2'd3;  // V * invr >> 32

    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 57;
    localparam int MUL_PARTS  = 4;

    typedef struct packed {
        logic       load;
        logic       sq;
        logic       sqrt_step;
        logic       div_step;
        logic       div_first;
        logic       mul_step;
        logic       mul_finish;
        logic [1:0] mul_kind;
        logic [1:0] mul_part;
        logic [1:0] axis;
        logic       acc_force;
        logic       acc_pot;
        logic       emit;
    } lp2p_cmd_t;

    typedef struct packed {
        logic last;
    } lp2p_status_t;

endpackage
`default_nettype wire

/* rtl/lp2p_datapath.sv */
`default_nettype none
module lp2p_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lp2p_pkg::lp2p_cmd_t  cmd,
    output lp2p_pkg::lp2p_status_t    status,
    input  wire logic signed [31:0]   target_x,
    input  wire logic signed [31:0]   target_y,
    input  wire logic signed [31:0]   target_z,
    input  wire logic signed [31:0]   source_x,
    input  wire logic signed [31:0]   source_y,
    input  wire logic signed [31:0]   source_z,
    input  wire logic signed [31:0]   source_charge,
    input  wire logic                 last_source,
    output logic signed [63:0]        potential,
    output logic signed [63:0]        force_x,
    output logic signed [63:0]        force_y,
    output logic signed [63:0]        force_z
);

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    function automatic logic [63:0] to_signed64(input logic [63:0] m, input logic neg);
        logic [63:0] r;
        if (neg)
        begin
            r = m[63] ? SMIN : (~m + 64'd1);
        end
        else
        begin
            r = m[63] ? SMAX : m;
        end
        return r;
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] s;
        logic [63:0] r;
        s = {x[63], x} + {y[63], y};
        if (s[64] != s[63])
        begin
            r = s[64] ? SMIN : SMAX;
        end
        else
        begin
            r = s[63:0];
        end
        return r;
    endfunction

    logic [31:0]  a_reg [3];
    logic [2:0]   dneg_reg;
    logic [31:0]  qm_reg;
    logic         qneg_reg;
    logic         last_reg;
    logic [65:0]  d2_reg;
    logic [36:0]  sq_rem_reg;
    logic [32:0]  root_reg;
    logic [34:0]  div_rem_reg;
    logic [56:0]  invr_reg;
    logic [127:0] macc_reg;
    logic [63:0]  pm_reg, u_reg, v_reg, fm_reg;
    logic [63:0]  psum_reg, fsum_reg [3];
    logic [63:0]  pot_out_reg, fout_reg [3];

    // Input differences and magnitudes.
    logic signed [32:0] d_in [3];
    logic [32:0]        a_in [3];
    logic [31:0]        qm_in;

    always_comb
    begin
        d_in[0] = {target_x[31], target_x} - {source_x[31], source_x};
        d_in[1] = {target_y[31], target_y} - {source_y[31], source_y};
        d_in[2] = {target_z[31], target_z} - {source_z[31], source_z};
        for (int k = 0; k < 3; k++)
        begin
            a_in[k] = d_in[k][32] ? (~d_in[k] + 33'd1) : d_in[k];
        end
        qm_in = source_charge[31] ? (~source_charge + 32'd1) : source_charge;
    end

    // Shared multiplier operands.
    logic [63:0]  op_a, op_b;
    logic [31:0]  mx, my;
    logic [63:0]  prod;
    logic [127:0] prod_sh;

    always_comb
    begin
        case (cmd.mul_kind)
            lp2p_pkg::KIND_P:
            begin
                op_a = {32'd0, qm_reg};
                op_b = {7'd0, invr_reg};
            end
            lp2p_pkg::KIND_U:
            begin
                op_a = {32'd0, a_reg[cmd.axis]};
                op_b = {7'd0, invr_reg};
            end
            lp2p_pkg::KIND_V:
            begin
                op_a = pm_reg;
                op_b = u_reg;
            end
            default:
            begin
                op_a = v_reg;
                op_b = {7'd0, invr_reg};
            end
        endcase
        if (cmd.sq)
        begin
            mx = a_reg[cmd.axis];
            my = a_reg[cmd.axis];
        end
        else
        begin
            mx = cmd.mul_part[0] ? op_a[63:32] : op_a[31:0];
            my = cmd.mul_part[1] ? op_b[63:32] : op_b[31:0];
        end
        prod = {32'd0, mx} * {32'd0, my};
        case (cmd.mul_part)
            2'd0:    prod_sh = {64'd0, prod};
            2'd3:    prod_sh = {prod, 64'd0};
            default: prod_sh = {32'd0, prod, 32'd0};
        endcase
    end

    // Shift and saturate the finished product.
    logic [63:0] mres;
    always_comb
    begin
        if (cmd.mul_kind == lp2p_pkg::KIND_P || cmd.mul_kind == lp2p_pkg::KIND_U)
        begin
            mres = (macc_reg[127:88] != '0) ? '1 : macc_reg[87:24];
        end
        else
        begin
            mres = (macc_reg[127:96] != '0) ? '1 : macc_reg[95:32];
        end
    end

    // Square root and division steps.
    logic [36:0] sq_sh, sq_trial;
    logic [34:0] dv_sh;
    logic        dv_ge;
    always_comb
    begin
        sq_sh    = {sq_rem_reg[34:0], d2_reg[65:64]};
        sq_trial = {2'd0, root_reg, 2'b01};
        dv_sh    = {div_rem_reg[33:0], cmd.div_first};
        dv_ge    = (root_reg != '0) && (dv_sh >= {2'd0, root_reg});
    end

    logic [63:0] fterm;
    always_comb
    begin
        fterm = to_signed64(fm_reg, qneg_reg == dneg_reg[cmd.axis]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_reg[k]    <= a_in[k][31:0];
                dneg_reg[k] <= d_in[k][32];
            end
            qm_reg      <= qm_in;
            qneg_reg    <= source_charge[31];
            last_reg    <= last_source;
            d2_reg      <= '0;
            sq_rem_reg  <= '0;
            root_reg    <= '0;
            div_rem_reg <= '0;
            invr_reg    <= '0;
        end
        if (cmd.sq)
        begin
            d2_reg <= d2_reg + {2'd0, prod};
        end
        if (cmd.sqrt_step)
        begin
            d2_reg <= {d2_reg[63:0], 2'b00};
            if (sq_sh >= sq_trial)
            begin
                sq_rem_reg <= sq_sh - sq_trial;
                root_reg   <= {root_reg[31:0], 1'b1};
            end
            else
            begin
                sq_rem_reg <= sq_sh;
                root_reg   <= {root_reg[31:0], 1'b0};
            end
        end
        if (cmd.div_step)
        begin
            div_rem_reg <= dv_ge ? (dv_sh - {2'd0, root_reg}) : dv_sh;
            invr_reg    <= {invr_reg[55:0], dv_ge};
        end
        if (cmd.mul_step)
        begin
            macc_reg <= (cmd.mul_part == 2'd0) ? prod_sh : (macc_reg + prod_sh);
        end
        if (cmd.mul_finish)
        begin
            case (cmd.mul_kind)
                lp2p_pkg::KIND_P: pm_reg <= mres;
                lp2p_pkg::KIND_U: u_reg  <= mres;
                lp2p_pkg::KIND_V: v_reg  <= mres;
                default:          fm_reg <= mres;
            endcase
        end
        if (cmd.emit)
        begin
            pot_out_reg <= psum_reg;
            for (int k = 0; k < 3; k++)
            begin
                fout_reg[k] <= fsum_reg[k];
            end
        end
    end

    // Accumulators are architectural state and clear at reset and on emit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psum_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                fsum_reg[k] <= '0;
            end
        end
        else if (cmd.emit)
        begin
            psum_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                fsum_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.acc_pot)
            begin
                psum_reg <= sat_add64(psum_reg, to_signed64(pm_reg, qneg_reg));
            end
            if (cmd.acc_force)
            begin
                fsum_reg[cmd.axis] <= sat_add64(fsum_reg[cmd.axis], fterm);
            end
        end
    end

    assign status.last = last_reg;
    assign potential   = pot_out_reg;
    assign force_x     = fout_reg[0];
    assign force_y     = fout_reg[1];
    assign force_z     = fout_reg[2];

endmodule
`default_nettype wire

/* rtl/lp2p_ctrl.sv */
`default_nettype none
module lp2p_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire lp2p_pkg::lp2p_status_t status,
    output lp2p_pkg::lp2p_cmd_t         cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_ACCF = 3'd5;
    localparam logic [2:0] S_ACCP = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] kind_reg, kind_next;
    logic [1:0] axis_reg, axis_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.mul_kind = kind_reg;
        cmd.mul_part = cnt_reg[1:0];
        cmd.axis     = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQ;
                    cnt_next   = '0;
                end
            end
            S_SQ:
            begin
                cmd.sq   = 1'b1;
                cmd.axis = cnt_reg[1:0];
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd2)
                begin
                    state_next = S_SQRT;
                    cnt_next   = '0;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'(lp2p_pkg::SQRT_STEPS - 1))
                begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                end
            end
            S_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == 6'd0);
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'(lp2p_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_MUL;
                    cnt_next   = '0;
                    kind_next  = lp2p_pkg::KIND_P;
                    axis_next  = '0;
                end
            end
            S_MUL:
            begin
                if (cnt_reg < 6'(lp2p_pkg::MUL_PARTS))
                begin
                    cmd.mul_step = 1'b1;
                    cnt_next     = cnt_reg + 6'd1;
                end
                else
                begin
                    cmd.mul_finish = 1'b1;
                    cnt_next       = '0;
                    case (kind_reg)
                        lp2p_pkg::KIND_P: kind_next = lp2p_pkg::KIND_U;
                        lp2p_pkg::KIND_U: kind_next = lp2p_pkg::KIND_V;
                        lp2p_pkg::KIND_V: kind_next = lp2p_pkg::KIND_F;
                        default:          state_next = S_ACCF;
                    endcase
                end
            end
            S_ACCF:
            begin
                cmd.acc_force = 1'b1;
                if (axis_reg == 2'd2)
                begin
                    state_next = S_ACCP;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    kind_next  = lp2p_pkg::KIND_U;
                    state_next = S_MUL;
                end
            end
            S_ACCP:
            begin
                cmd.acc_pot = 1'b1;
                state_next  = status.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            kind_reg      <= lp2p_pkg::KIND_P;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while still pending");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_SQ && cnt_reg == 6'd0))
        else $error("accepted item did not start squaring");

    a_mul_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (cnt_reg <= 6'(lp2p_pkg::MUL_PARTS)))
        else $error("multiplier part count out of range");

    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> status.last)
        else $error("emit without last source");

endmodule
`default_nettype wire

/* rtl/laplace_p2p_accumulator.sv */
`default_nettype none
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | target_x/y/z, source_x/y/z, source_charge, last_source
// output   | out_valid / out_ready| potential, force_x, force_y, force_z
//
// From accept to the next accept, each item passes through the accept, the squaring of each
// difference, 33 square root steps, 57 restoring division steps, ten products on the one
// shared 32x32 multiplier, 3 force and 1 potential accumulation.
// A last-source item adds an emit state, which waits while the prior result is still pending.
// Reset (rst_n, asynchronous, active low) clears the sums, the controller and out_valid.
// A stalled output holds its result register; the next item is taken meanwhile.
module laplace_p2p_accumulator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] target_x,
    input  wire logic signed [31:0] target_y,
    input  wire logic signed [31:0] target_z,
    input  wire logic signed [31:0] source_x,
    input  wire logic signed [31:0] source_y,
    input  wire logic signed [31:0] source_z,
    input  wire logic signed [31:0] source_charge,
    input  wire logic               last_source,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [63:0]      potential,
    output logic signed [63:0]      force_x,
    output logic signed [63:0]      force_y,
    output logic signed [63:0]      force_z
);

    // The controller sequences the pair computation; the datapath holds all values.
    lp2p_pkg::lp2p_cmd_t    cmd;
    lp2p_pkg::lp2p_status_t status;

    lp2p_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lp2p_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .target_x      (target_x),
        .target_y      (target_y),
        .target_z      (target_z),
        .source_x      (source_x),
        .source_y      (source_y),
        .source_z      (source_z),
        .source_charge (source_charge),
        .last_source   (last_source),
        .potential     (potential),
        .force_x       (force_x),
        .force_y       (force_y),
        .force_z       (force_z)
    );

endmodule
`default_nettype wire
